/* rtl/pts_pkg.sv */
// Shared constants and types for the priority task scheduler.
package pts_pkg;
   localparam int NumTasks = 32;
   localparam int NumPrio = 32;
   localparam int TaskW = 5;
   localparam int PrioW = 5;
   localparam logic [7:0] LockMax = 8'd255;
   localparam logic [15:0] SliceReset = 16'd10;

   localparam logic [2:0] ACT_READY = 3'd0;
   localparam logic [2:0] ACT_UNREADY = 3'd1;
   localparam logic [2:0] ACT_DELAY = 3'd2;
   localparam logic [2:0] ACT_WAKE = 3'd3;
   localparam logic [2:0] ACT_TICK = 3'd4;
   localparam logic [2:0] ACT_LOCK = 3'd5;
   localparam logic [2:0] ACT_UNLOCK = 3'd6;
   localparam logic [2:0] ACT_SCHED = 3'd7;

   typedef logic [TaskW-1:0] task_type;
   typedef logic [PrioW-1:0] prio_type;
endpackage

/* rtl/pts_prio_find.sv */
// Finds the lowest-numbered nonempty priority level in the ready bitmap.
module pts_prio_find (
   input  logic [pts_pkg::NumPrio-1:0] bitmap,
   output logic                        found,
   output pts_pkg::prio_type           level
);
   import pts_pkg::*;
   always_comb begin
      found = 1'b0;
      level = '0;
      for (int i = NumPrio - 1; i >= 0; i--) begin
         if (bitmap[i]) begin
            found = 1'b1;
            level = prio_type'(i);
         end
      end
   end
endmodule

/* rtl/priority_task_scheduler_unit.sv */
// Top level of the priority task scheduler with its event sequencer.
// The scheduler takes one request when start is high and busy is low, and
// answers it exactly once with a one-cycle rsp_valid strobe; the receiver cannot
// stall the answer. Delay and wake requests walk the delay order one link a
// cycle. A tick walks every delayed task one per cycle, pausing while an expired
// task that is not yet ready joins its FIFO, through a single shared 32-bit
// decrement-and-compare unit, then runs the slice step, with a slice rotation
// when the current ready task's slice runs out, and the priority pick. The queue
// links are plain register arrays with no reset; the cleared state is the control
// state, bitmap, counts, membership bits, slice values, slice reload, lock count,
// delay head and current task.
module priority_task_scheduler_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_action,
   input  logic [4:0]          req_task_id,
   input  logic [4:0]          req_priority_req,
   input  logic [31:0]         req_delay_ticks,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata,
   output logic                rsp_valid,
   output logic [4:0]          rsp_next_task,
   output logic                rsp_switch_now,
   output logic                rsp_sched_locked,
   output logic                rsp_none_ready,
   output logic [5:0]          rsp_woke_count
);
   import pts_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_DWALK   = 4'd2;
   localparam logic [3:0] S_WWALK   = 4'd3;
   localparam logic [3:0] S_TWALK   = 4'd4;
   localparam logic [3:0] S_SLICE   = 4'd5;
   localparam logic [3:0] S_SCHED   = 4'd6;
   localparam logic [3:0] S_DONE    = 4'd7;
   localparam logic [3:0] S_APPEND  = 4'd8;
   localparam logic [3:0] S_REMOVE  = 4'd9;

   // Return points after a FIFO append or removal.
   localparam logic [1:0] R_DONE  = 2'd0;
   localparam logic [1:0] R_TWALK = 2'd1;
   localparam logic [1:0] R_ROT   = 2'd2;
   localparam logic [1:0] R_SLEND = 2'd3;

   logic [3:0] state_ff, state_in;
   logic [1:0] ret_ff, ret_in;

   logic [15:0] reload_ff;
   logic [NumPrio-1:0] bitmap_ff;
   logic [5:0] qcount_ff [NumPrio];
   task_type qhead_ff [NumPrio];
   task_type qtail_ff [NumPrio];
   task_type lnext_ff [NumTasks];
   task_type lprev_ff [NumTasks];
   prio_type tprio_ff [NumTasks];
   logic [NumTasks-1:0] in_ready_ff;
   logic [NumTasks-1:0] in_delay_ff;
   logic [31:0] dleft_ff [NumTasks];
   task_type dnext_ff [NumTasks];
   task_type dhead_ff;
   logic [5:0] dcount_ff;
   logic [15:0] slice_ff [NumTasks];
   logic [7:0] lock_ff;
   task_type cur_ff;
   logic cur_valid_ff;

   // Request latch and walk state.
   logic [2:0] act_ff;
   task_type tid_ff;
   prio_type preq_ff;
   logic [31:0] ticks_ff;
   task_type x_ff, prev_ff;
   logic has_prev_ff;
   logic [5:0] idx_ff, n_ff;
   logic [5:0] woke_ff;
   logic sw_ff;
   task_type op_ff;   // task for append/remove

   // Shared decrement-and-compare unit.
   logic [31:0] dec_in, dec_out;
   logic dec_zero;
   assign dec_out = dec_in - 32'd1;
   assign dec_zero = (dec_out == 32'd0);

   logic found;
   prio_type level;
   pts_prio_find u_find (.bitmap(bitmap_ff), .found(found), .level(level));

   prio_type op_prio;
   assign op_prio = tprio_ff[op_ff];

   task_type sched_head;
   assign sched_head = qhead_ff[level];

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_next_task = cur_ff;
   assign rsp_switch_now = sw_ff;
   assign rsp_sched_locked = (lock_ff != 8'd0);
   assign rsp_none_ready = ~found;
   assign rsp_woke_count = woke_ff;

   always_comb begin
      dec_in = '0;
      unique case (state_ff)
         S_TWALK: dec_in = dleft_ff[x_ff];
         S_SLICE: dec_in = {16'd0, slice_ff[cur_ff]};
         default: dec_in = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_DECODE;
         S_DECODE: begin
            unique case (act_ff)
               ACT_READY: state_in = in_ready_ff[tid_ff] ? S_DONE : S_APPEND;
               ACT_UNREADY: state_in = in_ready_ff[tid_ff] ? S_REMOVE : S_DONE;
               ACT_DELAY: state_in = (in_delay_ff[tid_ff] || dcount_ff == 6'd0)
                                     ? S_DONE : S_DWALK;
               ACT_WAKE: state_in = in_delay_ff[tid_ff] ? S_WWALK : S_DONE;
               ACT_TICK: state_in = (dcount_ff == 6'd0) ? S_SLICE : S_TWALK;
               ACT_LOCK: state_in = S_DONE;
               ACT_UNLOCK: state_in = (lock_ff == 8'd1) ? S_SCHED : S_DONE;
               ACT_SCHED: state_in = S_SCHED;
               default: state_in = S_DONE;
            endcase
            ret_in = R_DONE;
         end
         S_DWALK: if (idx_ff + 6'd1 >= dcount_ff) state_in = S_DONE;
         S_WWALK: if (x_ff == tid_ff) state_in = S_DONE;
         S_TWALK: begin
            if (dec_zero && !in_ready_ff[x_ff]) begin
               state_in = S_APPEND;
               ret_in = R_TWALK;
            end else if (idx_ff + 6'd1 >= n_ff) begin
               state_in = S_SLICE;
            end
         end
         S_SLICE: begin
            if (!cur_valid_ff) state_in = S_SCHED;
            else if (dec_zero && in_ready_ff[cur_ff]) begin
               state_in = S_REMOVE;
               ret_in = R_ROT;
            end else state_in = S_SCHED;
         end
         S_APPEND: begin
            unique case (ret_ff)
               R_TWALK: state_in = (idx_ff + 6'd1 >= n_ff) ? S_SLICE : S_TWALK;
               R_SLEND: state_in = S_SCHED;
               default: state_in = S_DONE;
            endcase
         end
         S_REMOVE: begin
            if (ret_ff == R_ROT) begin
               state_in = S_APPEND;
               ret_in = R_SLEND;
            end else state_in = S_DONE;
         end
         S_SCHED: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff <= R_DONE;
         reload_ff <= SliceReset;
         bitmap_ff <= '0;
         in_ready_ff <= '0;
         in_delay_ff <= '0;
         dcount_ff <= '0;
         dhead_ff <= '0;
         lock_ff <= '0;
         cur_ff <= '0;
         cur_valid_ff <= 1'b0;
         sw_ff <= 1'b0;
         woke_ff <= '0;
         for (int i = 0; i < NumPrio; i++) qcount_ff[i] <= '0;
         for (int i = 0; i < NumTasks; i++) slice_ff[i] <= SliceReset;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         if (csr_we) reload_ff <= csr_wdata;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  act_ff <= req_action;
                  tid_ff <= req_task_id;
                  preq_ff <= req_priority_req;
                  ticks_ff <= req_delay_ticks;
                  sw_ff <= 1'b0;
                  woke_ff <= '0;
               end
            end
            S_DECODE: begin
               op_ff <= tid_ff;
               x_ff <= dhead_ff;
               has_prev_ff <= 1'b0;
               // A tick counts processed entries from zero; the delay walk
               // counts visited links from one.
               idx_ff <= (act_ff == ACT_TICK) ? 6'd0 : 6'd1;
               n_ff <= dcount_ff;
               case (act_ff)
                  ACT_READY: if (!in_ready_ff[tid_ff]) begin
                     tprio_ff[tid_ff] <= preq_ff;
                  end
                  ACT_DELAY: begin
                     dleft_ff[tid_ff] <= ticks_ff;
                     if (!in_delay_ff[tid_ff]) begin
                        in_delay_ff[tid_ff] <= 1'b1;
                        dcount_ff <= dcount_ff + 6'd1;
                        if (dcount_ff == 6'd0) dhead_ff <= tid_ff;
                     end
                  end
                  ACT_LOCK: if (lock_ff != LockMax) lock_ff <= lock_ff + 8'd1;
                  ACT_UNLOCK: if (lock_ff != 8'd0) lock_ff <= lock_ff - 8'd1;
                  default: ;
               endcase
            end
            S_DWALK: begin
               // Walk to the last linked entry, then chain the new task on.
               if (idx_ff + 6'd1 >= dcount_ff) dnext_ff[x_ff] <= tid_ff;
               else begin
                  x_ff <= dnext_ff[x_ff];
                  idx_ff <= idx_ff + 6'd1;
               end
            end
            S_WWALK: begin
               if (x_ff == tid_ff) begin
                  if (has_prev_ff) dnext_ff[prev_ff] <= dnext_ff[x_ff];
                  else dhead_ff <= dnext_ff[x_ff];
                  dcount_ff <= dcount_ff - 6'd1;
                  in_delay_ff[x_ff] <= 1'b0;
               end else begin
                  prev_ff <= x_ff;
                  has_prev_ff <= 1'b1;
                  x_ff <= dnext_ff[x_ff];
               end
            end
            S_TWALK: begin
               dleft_ff[x_ff] <= dec_out;
               if (dec_zero) begin
                  if (has_prev_ff) dnext_ff[prev_ff] <= dnext_ff[x_ff];
                  else dhead_ff <= dnext_ff[x_ff];
                  dcount_ff <= dcount_ff - 6'd1;
                  in_delay_ff[x_ff] <= 1'b0;
                  if (woke_ff != 6'd63) woke_ff <= woke_ff + 6'd1;
                  op_ff <= x_ff;
               end else begin
                  prev_ff <= x_ff;
                  has_prev_ff <= 1'b1;
               end
               x_ff <= dnext_ff[x_ff];
               if (!(dec_zero && !in_ready_ff[x_ff])) idx_ff <= idx_ff + 6'd1;
            end
            S_SLICE: begin
               if (cur_valid_ff) begin
                  if (dec_zero) slice_ff[cur_ff] <= reload_ff;
                  else slice_ff[cur_ff] <= dec_out[15:0];
                  op_ff <= cur_ff;
               end
            end
            S_APPEND: begin
               if (qcount_ff[op_prio] == 6'd0) qhead_ff[op_prio] <= op_ff;
               else begin
                  lnext_ff[qtail_ff[op_prio]] <= op_ff;
                  lprev_ff[op_ff] <= qtail_ff[op_prio];
               end
               qtail_ff[op_prio] <= op_ff;
               qcount_ff[op_prio] <= qcount_ff[op_prio] + 6'd1;
               bitmap_ff[op_prio] <= 1'b1;
               in_ready_ff[op_ff] <= 1'b1;
               if (ret_ff == R_TWALK) idx_ff <= idx_ff + 6'd1;
            end
            S_REMOVE: begin
               if (qhead_ff[op_prio] == op_ff) qhead_ff[op_prio] <= lnext_ff[op_ff];
               else lnext_ff[lprev_ff[op_ff]] <= lnext_ff[op_ff];
               if (qtail_ff[op_prio] == op_ff) qtail_ff[op_prio] <= lprev_ff[op_ff];
               else lprev_ff[lnext_ff[op_ff]] <= lprev_ff[op_ff];
               qcount_ff[op_prio] <= qcount_ff[op_prio] - 6'd1;
               if (qcount_ff[op_prio] == 6'd1) bitmap_ff[op_prio] <= 1'b0;
               in_ready_ff[op_ff] <= 1'b0;
            end
            S_SCHED: begin
               if (lock_ff == 8'd0 && found &&
                   (!cur_valid_ff || sched_head != cur_ff)) begin
                  cur_ff <= sched_head;
                  cur_valid_ff <= 1'b1;
                  sw_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

/* rtl/pts_checker.sv */
// Port-level checker for the priority task scheduler, bound to the top level.
module pts_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted request did not raise busy");
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response outside busy");
   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after response");
   a_no_double: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("repeated response");
   a_reset_idle: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !busy && !rsp_valid) else $error("not idle after reset");
endmodule

bind priority_task_scheduler_unit pts_checker u_pts_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid)
);
